[hw/rtl/hne_pkg.sv]
// hne_pkg: constants shared by the heightfield normal encoder.
// Fixed-point scale factors, field widths and edge mask bit positions.
// No dependencies.
package hne_pkg;

	localparam int HW = 16;            // height width
	localparam int KW = 24;            // vertical term width, unsigned Q16.8
	localparam int QW = 16;            // quotient bits of one normalise division
	localparam int NW = 17;            // Q1.15 unit component, signed, +-32768

	localparam logic [KW-1:0] VTERM_RESET   = 24'd512;
	localparam logic [16:0]   SQRT2_Q16     = 17'd92682;
	localparam logic [15:0]   INV_SQRT2_Q15 = 16'd23170;
	localparam logic [16:0]   ONE_Q15       = 17'd32768;

	localparam int EDGE_WEST  = 0;
	localparam int EDGE_EAST  = 1;
	localparam int EDGE_NORTH = 2;
	localparam int EDGE_SOUTH = 3;

endpackage

[hw/rtl/hne_sqrt.sv]
// hne_sqrt: pipelined integer square root, one result bit per stage.
// Carries a side payload and a valid bit alongside. Depends on nothing.
module hne_sqrt #(
	parameter int VW = 52,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [VW-1:0]     radicand,
	input  logic [PW-1:0]     in_side,
	output logic              out_valid,
	output logic [VW/2-1:0]   root,
	output logic [PW-1:0]     out_side
);
	localparam int RW = VW / 2;
	localparam int MW = RW + 2;

	logic            val_s  [RW+1];
	logic [VW-1:0]   rad_s  [RW+1];
	logic [MW-1:0]   rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [PW-1:0]   side_s [RW+1];

	assign val_s[0]  = in_valid;
	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		localparam int B = RW - 1 - i;
		logic [MW+1:0] cur;
		logic [MW+1:0] trial;
		logic          hit;

		assign cur   = {rem_s[i], rad_s[i][2*B+1 -: 2]};
		assign trial = {{(MW-RW){1'b0}}, root_s[i], 2'b01};
		assign hit   = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[i+1] <= 1'b0;
			end else if (en) begin
				val_s[i+1] <= val_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= rad_s[i];
				side_s[i+1] <= side_s[i];
				rem_s[i+1]  <= hit ? MW'(cur - trial) : MW'(cur);
				root_s[i+1] <= {root_s[i][RW-2:0], hit};
			end
		end
	end

	assign out_valid = val_s[RW];
	assign root      = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

[hw/rtl/hne_div.sv]
// hne_div: three-lane pipelined restoring divider sharing one divisor,
// one quotient bit per stage. Depends on nothing.
module hne_div #(
	parameter int NW = 41,
	parameter int DW = 26,
	parameter int QW = 16,
	parameter int PW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NW-1:0]   num [3],
	input  logic [DW-1:0]   den,
	input  logic [PW-1:0]   in_side,
	output logic            out_valid,
	output logic [QW-1:0]   quo [3],
	output logic [PW-1:0]   out_side
);
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic            val_s  [QW+1];
	logic [DW-1:0]   den_s  [QW+1];
	logic [PW-1:0]   side_s [QW+1];
	logic [NW-1:0]   rem_s  [QW+1][3];
	logic [QW-1:0]   q_s    [QW+1][3];

	assign val_s[0]  = in_valid;
	assign den_s[0]  = den;
	assign side_s[0] = in_side;

	for (genvar l = 0; l < 3; l++) begin : g_init
		assign rem_s[0][l] = num[l];
		assign q_s[0][l]   = '0;
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int J = QW - 1 - i;
		logic [CW-1:0] dsh;

		assign dsh = CW'(den_s[i]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[i+1] <= 1'b0;
			end else if (en) begin
				val_s[i+1] <= val_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [CW-1:0] rx;
			logic          hit;

			assign rx  = CW'(rem_s[i][l]);
			assign hit = rx >= dsh;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1][l] <= hit ? NW'(rx - dsh) : rem_s[i][l];
					q_s[i+1][l]   <= {q_s[i][l][QW-2:0], hit};
				end
			end
		end
	end

	assign out_valid = val_s[QW];
	assign out_side  = side_s[QW];

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign quo[l] = q_s[QW][l];
	end

endmodule

[hw/rtl/hne_unit.sv]
// hne_unit: normalises a signed 3-vector to Q1.15 (squares, sum, root, divide).
// Depends on hne_pkg, hne_sqrt and hne_div.
module hne_unit #(
	parameter int VW = 26
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [VW-1:0]     v_in [3],
	output logic                     out_valid,
	output logic signed [hne_pkg::NW-1:0] n_out [3]
);
	localparam int SW = 2 * VW;
	localparam int DNW = VW + 15;

	logic signed [SW-1:0] sq_w [3];
	logic [SW-1:0]        sq_s1 [3];
	logic signed [VW-1:0] v_s1 [3];
	logic signed [VW-1:0] v_s2 [3];
	logic [SW-1:0]        sum_s2;
	logic                 val_s1, val_s2;

	logic                 sq_valid;
	logic [VW-1:0]        root;
	logic [3*VW-1:0]      sq_side;

	logic [DNW-1:0]       num [3];
	logic [3:0]           dv_side;
	logic                 dv_valid;
	logic [hne_pkg::QW-1:0] quo [3];
	logic [3:0]           dq_side;

	logic                 val_s3;
	logic signed [hne_pkg::NW-1:0] n_s3 [3];

	for (genvar l = 0; l < 3; l++) begin : g_sq
		assign sq_w[l] = v_in[l] * v_in[l];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
		end else if (en) begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sq_s1[l] <= sq_w[l];
				v_s1[l]  <= v_in[l];
				v_s2[l]  <= v_s1[l];
			end
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	hne_sqrt #(.VW(SW), .PW(3*VW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (val_s2),
		.radicand (sum_s2),
		.in_side  ({v_s2[2], v_s2[1], v_s2[0]}),
		.out_valid(sq_valid),
		.root     (root),
		.out_side (sq_side)
	);

	for (genvar l = 0; l < 3; l++) begin : g_num
		logic signed [VW-1:0] vc;
		logic [VW-1:0]        mag;
		assign vc      = sq_side[l*VW +: VW];
		assign mag     = vc[VW-1] ? VW'(-vc) : VW'(vc);
		assign num[l]  = {mag, 15'd0};
		assign dv_side[l] = vc[VW-1];
	end
	assign dv_side[3] = root == '0;

	hne_div #(.NW(DNW), .DW(VW), .QW(hne_pkg::QW), .PW(4)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.num      (num),
		.den      (root),
		.in_side  (dv_side),
		.out_valid(dv_valid),
		.quo      (quo),
		.out_side (dq_side)
	);

	// zero-length vector is taken as straight up
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (dq_side[3]) begin
					n_s3[l] <= (l == 2) ? hne_pkg::ONE_Q15 : '0;
				end else if (dq_side[l]) begin
					n_s3[l] <= -$signed({1'b0, quo[l]});
				end else begin
					n_s3[l] <= $signed({1'b0, quo[l]});
				end
			end
		end
	end

	assign out_valid = val_s3;
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign n_out[l] = n_s3[l];
	end

endmodule

[hw/rtl/heightfield_normal_encoder.sv]
// heightfield_normal_encoder: 3x3 neighbourhood to encoded normal, 3 x 16 bit.
// Depends on hne_pkg and hne_unit.
//
// Usage:
//   s_* stream: one neighbourhood request per accepted beat. s_tdata holds the
//   nine heights and the edge mask, s_tuser the row and column parity.
//   m_* stream: one encoded normal per request whose row and column are both
//   even; odd pixels are consumed and produce nothing.
//   cfg_wr_en / cfg_wr_data write the vertical term (Q16.8); write it only while
//   the pipeline is empty.
// Path: requests pass from input accept to output valid through two normalise
//   units in series (pipelined root and 16-stage divider, one bit per stage).
// Throughput: one request per clock while the output is not stalled.
// Reset: clears all valid bits, output valid included; vertical term returns
//   to 2.0.
// Stall: when m_tready is low with a result held, the whole pipeline freezes
//   and s_tready drops; nothing is lost or repeated.
module heightfield_normal_encoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// centre, east, north, west, south, southeast, northwest, southwest,
	// northeast heights (16 bit each), edge_mask (4 bit), 4 bits zero
	input  logic [151:0]  s_tdata,
	// row_odd, col_odd
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// normal_red, normal_green, normal_blue (16 bit each)
	output logic [47:0]   m_tdata,
	input  logic          cfg_wr_en,
	input  logic [23:0]   cfg_wr_data
);
	localparam int HW = hne_pkg::HW;
	localparam int V1 = 26;
	localparam int V3 = 18;

	logic [hne_pkg::KW-1:0] vterm_q;
	logic en;

	logic [HW-1:0] h [9];
	logic [3:0]    emask;
	logic          w_e, e_e, n_e, s_e;

	logic          val_s1;
	logic [HW-1:0] a_s1, b_s1, c_s1, d_s1, x_s1, y_s1, z_s1, w_s1;
	logic [hne_pkg::KW-1:0] k_s1;

	logic          val_s2;
	logic signed [V1-1:0] v1_s2 [3];
	logic signed [V1-1:0] v2_s2 [3];

	logic          u1_valid, u2_valid;
	logic signed [hne_pkg::NW-1:0] n1 [3];
	logic signed [hne_pkg::NW-1:0] n2 [3];

	logic          val_s3;
	logic signed [hne_pkg::NW-1:0] n1_s3 [3];
	logic signed [32:0]            t_s3 [3];

	logic          val_s4;
	logic signed [V3-1:0] s_s4 [3];

	logic          u3_valid;
	logic signed [hne_pkg::NW-1:0] n3 [3];

	logic [15:0]   enc [3];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vterm_q <= hne_pkg::VTERM_RESET;
		end else if (cfg_wr_en) begin
			vterm_q <= cfg_wr_data;
		end
	end

	for (genvar i = 0; i < 9; i++) begin : g_h
		assign h[i] = s_tdata[i*HW +: HW];
	end
	assign emask = s_tdata[147:144];
	assign w_e   = emask[hne_pkg::EDGE_WEST];
	assign e_e   = emask[hne_pkg::EDGE_EAST];
	assign n_e   = emask[hne_pkg::EDGE_NORTH];
	assign s_e   = emask[hne_pkg::EDGE_SOUTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1   <= 1'b0;
			val_s2   <= 1'b0;
			val_s3   <= 1'b0;
			val_s4   <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			val_s1   <= s_tvalid && !s_tuser[0] && !s_tuser[1];
			val_s2   <= val_s1;
			val_s3   <= u1_valid && u2_valid;
			val_s4   <= val_s3;
			m_tvalid <= u3_valid;
		end
	end

	// missing neighbours fall back to the centre height
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= e_e ? h[1] : h[0];
			b_s1 <= n_e ? h[2] : h[0];
			c_s1 <= w_e ? h[3] : h[0];
			d_s1 <= s_e ? h[4] : h[0];
			x_s1 <= (e_e && s_e) ? h[5] : h[0];
			y_s1 <= (w_e && n_e) ? h[6] : h[0];
			z_s1 <= (w_e && s_e) ? h[7] : h[0];
			w_s1 <= (e_e && n_e) ? h[8] : h[0];
			k_s1 <= vterm_q;
		end
	end

	logic signed [16:0] dx1, dy1, dx2, dy2;
	logic [40:0]        kd;
	assign dx1 = $signed({1'b0, c_s1}) - $signed({1'b0, a_s1});
	assign dy1 = $signed({1'b0, b_s1}) - $signed({1'b0, d_s1});
	assign dx2 = $signed({1'b0, z_s1}) - $signed({1'b0, w_s1});
	assign dy2 = $signed({1'b0, y_s1}) - $signed({1'b0, x_s1});
	assign kd  = 41'(k_s1) * 41'(hne_pkg::SQRT2_Q16);

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s2[0] <= {dx1[16], dx1, 8'd0};
			v1_s2[1] <= {dy1[16], dy1, 8'd0};
			v1_s2[2] <= $signed({2'b00, k_s1});
			v2_s2[0] <= {dx2[16], dx2, 8'd0};
			v2_s2[1] <= {dy2[16], dy2, 8'd0};
			v2_s2[2] <= $signed({1'b0, kd[40:16]});
		end
	end

	hne_unit #(.VW(V1)) u_axis (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (val_s2),
		.v_in     (v1_s2),
		.out_valid(u1_valid),
		.n_out    (n1)
	);

	hne_unit #(.VW(V1)) u_diag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (val_s2),
		.v_in     (v2_s2),
		.out_valid(u2_valid),
		.n_out    (n2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				n1_s3[l] <= n1[l];
				t_s3[l]  <= 33'(n2[l]) * $signed({1'b0, hne_pkg::INV_SQRT2_Q15});
			end
		end
	end

	// divide by 2^15 rounding toward zero
	for (genvar l = 0; l < 3; l++) begin : g_sum
		logic signed [32:0] tb;
		logic signed [32:0] tq;
		assign tb = t_s3[l][32] ? t_s3[l] + 33'sd32767 : t_s3[l];
		assign tq = tb >>> 15;

		always_ff @(posedge clk) begin
			if (en) begin
				s_s4[l] <= V3'(n1_s3[l]) + V3'(tq);
			end
		end
	end

	hne_unit #(.VW(V3)) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (val_s4),
		.v_in     (s_s4),
		.out_valid(u3_valid),
		.n_out    (n3)
	);

	for (genvar l = 0; l < 3; l++) begin : g_enc
		logic [16:0] u;
		logic [32:0] p;
		assign u      = 17'(n3[l]) + hne_pkg::ONE_Q15;
		assign p      = {u, 16'd0} - {16'd0, u};
		assign enc[l] = p[31:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {enc[2], enc[1], enc[0]};
		end
	end

endmodule

[test/tb_top.sv]
// tb_top: stimulus, prediction and checking for heightfield_normal_encoder.
// Drives random and directed neighbourhoods with bursty sends and receiver stalls,
// and predicts each encoded normal in fixed point. Depends on hne_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int LATENCY = 87;

	typedef struct packed {
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} normal_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         cfg_wr_en;
	logic [23:0]  cfg_wr_data;

	logic [23:0]  vterm;
	normal_t      normals_due[$];
	int           mismatches;
	int           results_seen;
	int           requests_sent;
	int           burst_left;
	bit           stall_on;

	heightfield_normal_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	task automatic to_unit(input longint v[3], output longint n[3]);
		longint unsigned sq;
		longint mag;
		sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		mag = longint'(int_sqrt(sq));
		if (mag == 0) begin
			n[0] = 0; n[1] = 0; n[2] = 32768;
		end else begin
			for (int i = 0; i < 3; i++) n[i] = (v[i] * 32768) / mag;
		end
	endtask

	function automatic logic [15:0] encode_comp(longint c);
		longint unsigned t;
		t = longint'(c + 32768) * 65535;
		return t[31:16];
	endfunction

	task automatic predict_normal(input logic [151:0] d);
		longint o, a, b, c, s, x, y, z, w, k;
		longint v1[3], v2[3], n1[3], n2[3], sum[3], n[3];
		logic [3:0] m;
		bit we, ea, no, so;
		normal_t r;
		o = d[15:0];    a = d[31:16];   b = d[47:32];   c = d[63:48];
		s = d[79:64];   x = d[95:80];   y = d[111:96];  z = d[127:112];
		w = d[143:128]; m = d[147:144];
		we = m[hne_pkg::EDGE_WEST];  ea = m[hne_pkg::EDGE_EAST];
		no = m[hne_pkg::EDGE_NORTH]; so = m[hne_pkg::EDGE_SOUTH];
		k = vterm;
		if (!ea) a = o;
		if (!no) b = o;
		if (!we) c = o;
		if (!so) s = o;
		if (!(ea && so)) x = o;
		if (!(we && no)) y = o;
		if (!(we && so)) z = o;
		if (!(ea && no)) w = o;
		v1[0] = (c - a) * 256; v1[1] = (b - s) * 256; v1[2] = k;
		v2[0] = (z - w) * 256; v2[1] = (y - x) * 256; v2[2] = (k * 92682) >>> 16;
		to_unit(v1, n1);
		to_unit(v2, n2);
		for (int i = 0; i < 3; i++) sum[i] = n1[i] + (n2[i] * 23170) / 32768;
		to_unit(sum, n);
		r.red = encode_comp(n[0]);
		r.green = encode_comp(n[1]);
		r.blue = encode_comp(n[2]);
		normals_due.push_back(r);
	endtask

	// receiver: stalls in runs of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 15) == 0) stall_on = ~stall_on;
			m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		normal_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (normals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected normal %h", got);
			end else begin
				want = normals_due.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("normal mismatch: exp r%h g%h b%h got r%h g%h b%h",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
				end
			end
		end
	end

	// valid stays high through a burst and drops only before a gap
	task automatic send_request(input logic [151:0] d, input logic [1:0] u);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= u;
		do @(posedge clk); while (!s_tready);
		if (u == 2'b00) predict_normal(d);
		requests_sent++;
		if (burst_left == 0) s_tvalid <= 1'b0;
	endtask

	function automatic logic [151:0] pack_hood(logic [15:0] h[9], logic [3:0] m);
		logic [151:0] d;
		d = '0;
		for (int i = 0; i < 9; i++) d[i*16 +: 16] = h[i];
		d[147:144] = m;
		return d;
	endfunction

	task automatic drain;
		int guard;
		guard = 0;
		if (burst_left != 0) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
		end
		while (normals_due.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_vterm(input logic [23:0] val);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vterm = val;
	endtask

	task automatic random_hood(output logic [151:0] d);
		logic [15:0] h[9];
		logic [15:0] base;
		base = $urandom;
		for (int i = 0; i < 9; i++) begin
			case ($urandom_range(0, 3))
				0: h[i] = $urandom;
				1: h[i] = base;
				2: h[i] = base + 16'($urandom_range(0, 64)) - 16'd32;
				default: h[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			endcase
		end
		d = pack_hood(h, 4'($urandom));
	endtask

	task automatic test_directed;
		logic [15:0] h[9];
		for (int i = 0; i < 9; i++) h[i] = 16'h8000;
		send_request(pack_hood(h, 4'hF), 2'b00);          // flat patch
		for (int i = 0; i < 9; i++) h[i] = (i % 2) ? 16'hFFFF : 16'h0000;
		for (int m = 0; m < 16; m++) send_request(pack_hood(h, 4'(m)), 2'b00);
		for (int i = 0; i < 9; i++) h[i] = (i % 2) ? 16'h0000 : 16'hFFFF;
		send_request(pack_hood(h, 4'hF), 2'b00);
		send_request(pack_hood(h, 4'hF), 2'b01);          // odd pixels give nothing
		send_request(pack_hood(h, 4'hF), 2'b10);
		send_request(pack_hood(h, 4'hF), 2'b11);
	endtask

	task automatic test_flat_zero_term;
		logic [15:0] h[9];
		write_vterm(24'd0);
		for (int i = 0; i < 9; i++) h[i] = 16'h1234;
		send_request(pack_hood(h, 4'hF), 2'b00);          // zero-length vector
		send_request(pack_hood(h, 4'h0), 2'b00);
		h[1] = 16'hFFFF;
		send_request(pack_hood(h, 4'hF), 2'b00);
	endtask

	task automatic test_random(input int count);
		logic [151:0] d;
		for (int i = 0; i < count; i++) begin
			random_hood(d);
			send_request(d, ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00);
			if (i == count / 2) drain();                  // sender waits for all results
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		vterm = hne_pkg::VTERM_RESET;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		burst_left = 0;
		stall_on = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150);
		test_flat_zero_term();
		test_random(150);
		write_vterm(24'hFFFFFF);
		test_directed();
		test_random(150);
		write_vterm(24'($urandom_range(1, 4096)));
		test_random(150);
		drain();
		$display("covered %0d requests, %0d normals checked, four vertical terms incl. 0 and max",
			requests_sent, results_seen);
		if (mismatches == 0 && normals_due.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("%0d mismatches, %0d normals missing", mismatches, normals_due.size());
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
